[rtl/fmds_pkg.sv]
package fmds_pkg;

    // One sample tick from the read line.
    typedef struct packed {
        logic flux_pulse;
        logic resync;
        logic enable;
    } sample_word_t;

    // One finished bit cell.
    typedef struct packed {
        logic data_bit;
        logic ended_by_clock;
    } cell_word_t;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CELL_LENGTH  = 2'd0,
        CFG_WINDOW_OPEN  = 2'd1,
        CFG_WINDOW_CLOSE = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    localparam logic [CFG_DATA_BITS-1:0] CELL_LENGTH_RESET  = 8'd64;
    localparam logic [CFG_DATA_BITS-1:0] WINDOW_OPEN_RESET  = 8'd24;
    localparam logic [CFG_DATA_BITS-1:0] WINDOW_CLOSE_RESET = 8'd40;

endpackage

[rtl/fm_fixed_rate_data_separator_top.sv]
// A sample word is held in the input register and its cell word, if any, is then
// registered in the output register.
// Throughput: one sample word per clock; the cell counter and flags update
// combinationally, so only a stalled output register holds the input back.
// Reset (rst_n low, asynchronous): both registers empty, cell position and
// flags cleared, and the three timing registers return to 64, 24 and 40 ticks.
module fm_fixed_rate_data_separator_top #(
    parameter int POSITION_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  fmds_pkg::sample_word_t                 sample,
    output logic                                   bit_valid,
    input  logic                                   bit_stall,
    output fmds_pkg::cell_word_t                   cell_bit,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fmds_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fmds_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import fmds_pkg::*;

    // Comparisons between the cell position and the 8-bit timing registers
    // are done at the wider of the two widths, so a narrow counter still
    // sees a long cell length correctly (it then times out by saturation).
    localparam int CMP_BITS = (POSITION_BITS > CFG_DATA_BITS) ? POSITION_BITS : CFG_DATA_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    // Timing registers. The user must write them only while the separator is idle;
    // the block does not enforce this, and the write port is always ready.
    logic [CFG_DATA_BITS-1:0] cell_length_reg;
    logic [CFG_DATA_BITS-1:0] window_open_reg;
    logic [CFG_DATA_BITS-1:0] window_close_reg;

    // Input register: the sample word waiting to be processed.
    logic         in_valid_reg;
    sample_word_t in_word_reg;

    // Separator state.
    logic [POSITION_BITS-1:0] position_reg;
    logic [POSITION_BITS-1:0] position_next;
    logic                     clock_seen_reg;
    logic                     clock_seen_next;
    logic                     data_seen_reg;
    logic                     data_seen_next;

    // Output register.
    logic       out_valid_reg;
    cell_word_t out_word_reg;

    logic       emit;
    cell_word_t emit_word;
    logic       advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_length_reg  <= CELL_LENGTH_RESET;
            window_open_reg  <= WINDOW_OPEN_RESET;
            window_close_reg <= WINDOW_CLOSE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CELL_LENGTH:  cell_length_reg  <= cfg_data;
                CFG_WINDOW_OPEN:  window_open_reg  <= cfg_data;
                CFG_WINDOW_CLOSE: window_close_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The held word is processed whenever the output register is free or
    // is handing its word over in this cycle. The input register refills
    // in the same cycle, so a word can enter on every clock unless the output stalls.
    assign advance      = in_valid_reg && (!out_valid_reg || !bit_stall);
    assign sample_stall = in_valid_reg && !advance;

    always_comb
    begin
        logic [CMP_BITS-1:0] pos_wide;
        logic                timeout;
        logic                in_window;
        logic                past_window;

        pos_wide        = '0;
        timeout         = 1'b0;
        in_window       = 1'b0;
        past_window     = 1'b0;
        position_next   = position_reg;
        clock_seen_next = clock_seen_reg;
        data_seen_next  = data_seen_reg;
        emit            = 1'b0;
        emit_word       = '0;

        if (in_word_reg.resync)
        begin
            // Resync wins over everything, enabled or not; any pulse is dropped.
            position_next   = '0;
            clock_seen_next = 1'b0;
            data_seen_next  = 1'b0;
        end
        else if (in_word_reg.enable)
        begin
            // Timeout is checked first: the cell has run its full length or
            // the counter has hit its ceiling. The new cell has no clock yet.
            pos_wide = CMP_BITS'(position_reg);
            timeout  = (pos_wide >= CMP_BITS'(cell_length_reg)) || (position_reg == POS_MAX);
            if (timeout)
            begin
                emit                     = 1'b1;
                emit_word.data_bit       = data_seen_reg;
                emit_word.ended_by_clock = 1'b0;
                position_next            = '0;
                clock_seen_next          = 1'b0;
                data_seen_next           = 1'b0;
            end

            pos_wide    = CMP_BITS'(position_next);
            in_window   = (pos_wide >= CMP_BITS'(window_open_reg))
                       && (pos_wide < CMP_BITS'(window_close_reg));
            past_window = pos_wide >= CMP_BITS'(window_close_reg);

            if (in_word_reg.flux_pulse)
            begin
                priority if (!clock_seen_next)
                begin
                    // First pulse of the cell is its clock and sets the phase.
                    position_next   = '0;
                    clock_seen_next = 1'b1;
                end
                else if (in_window)
                begin
                    data_seen_next = 1'b1;
                end
                else if (past_window)
                begin
                    // Clock of the next cell: close this one out. A timeout
                    // cannot coincide here, since it already cleared the clock.
                    emit                     = 1'b1;
                    emit_word.data_bit       = data_seen_next;
                    emit_word.ended_by_clock = 1'b1;
                    position_next            = '0;
                    clock_seen_next          = 1'b1;
                    data_seen_next           = 1'b0;
                end
                else
                begin
                    // Early pulse before the window: ignored.
                end
            end

            if (position_next != POS_MAX)
            begin
                position_next = position_next + POS_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            position_reg   <= '0;
            clock_seen_reg <= 1'b0;
            data_seen_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!sample_stall)
            begin
                in_valid_reg <= sample_valid;
            end

            if (advance)
            begin
                position_reg   <= position_next;
                clock_seen_reg <= clock_seen_next;
                data_seen_reg  <= data_seen_next;
                out_valid_reg  <= emit;
            end
            else if (!bit_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            in_word_reg <= sample;
        end
        if (advance && emit)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign bit_valid = out_valid_reg;
    assign cell_bit  = out_word_reg;

endmodule

[rtl/fmds_checker.sv]
module fmds_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_valid,
    input logic                                sample_stall,
    input fmds_pkg::sample_word_t              sample,
    input logic                                bit_valid,
    input logic                                bit_stall,
    input fmds_pkg::cell_word_t                cell_bit,
    input logic                                cfg_valid,
    input logic                                cfg_ready
);

    // A waiting cell word stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bit_valid && bit_stall |=> bit_valid && $stable(cell_bit))
        else $error("cell word changed or dropped while stalled");

    // A stalled sample word is held by the sender until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sample))
        else $error("sample word changed or dropped while stalled");

    // The input side only backs up when the output side is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> bit_valid && bit_stall)
        else $error("input stalled without a stalled output word");

    // Nothing comes out in the first cycle after reset is released.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !bit_valid && !sample_stall)
        else $error("output or stall active right after reset");

    // The timing registers never refuse a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind fm_fixed_rate_data_separator_top fmds_checker u_fmds_checker (.*);
